// ===== rtl/core/wov_pkg.sv =====
package wov_pkg;

	localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;
	localparam logic signed [19:0] PI_Q16 = 20'sd205887;
	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [18:0] CORDIC_GAIN_Q16 = 19'sd39797;
	localparam logic [31:0] NS_PER_S = 32'd1000000000;

	typedef struct packed {
		logic        action;
		logic [3:0]  unit_id;
		logic signed [15:0] steer_angle;
		logic signed [31:0] displacement;
		logic [63:0] period_start_ns;
		logic [63:0] period_end_ns;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic signed [31:0] linear_velocity;
		logic signed [31:0] yaw_rate;
		logic [31:0] invalid_count;
	} out_t;

	typedef enum logic [2:0] {
		CFG_WHEEL_DIST = 3'd0,
		CFG_MAX_LINEAR = 3'd1,
		CFG_MAX_YAW    = 3'd2,
		CFG_MAX_PERIOD = 3'd3,
		CFG_WHEEL_ID   = 3'd4,
		CFG_SERVO_ID   = 3'd5
	} cfg_idx_e;

	typedef enum logic [2:0] {
		STAT_IGNORED    = 3'd0,
		STAT_ANGLE      = 3'd1,
		STAT_ACCEPTED   = 3'd2,
		STAT_REJECTED   = 3'd3,
		STAT_BAD_PERIOD = 3'd4
	} stat_e;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SPD_MUL,
		ST_SPD_GO,
		ST_SPD_DIV,
		ST_LIN_MUL,
		ST_CMP_MUL,
		ST_YAW_GO,
		ST_YAW_DIV,
		ST_CHECK,
		ST_DONE
	} state_e;

	typedef struct packed {
		logic [30:0] wheel_distance;
		logic [30:0] max_linear_speed;
		logic [30:0] max_yaw_rate;
		logic [31:0] max_period_ns;
		logic [3:0]  chosen_wheel;
		logic [3:0]  chosen_servo;
	} cfg_t;

	typedef struct packed {
		logic  load;
		logic  store_angle;
		logic  code_we;
		stat_e code;
		logic  spd_mul;
		logic  spd_go;
		logic  spd_take;
		logic  lin_mul;
		logic  cmp_mul;
		logic  yaw_go;
		logic  yaw_take;
		logic  commit;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic is_enc;
		logic match;
		logic bad_period;
		logic div_done;
		logic cordic_busy;
		logic out_free;
	} sts_t;

	function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
		logic signed [19:0] r;
		begin
			unique case (i)
				4'd0:  r = 20'sd51472;
				4'd1:  r = 20'sd30386;
				4'd2:  r = 20'sd16055;
				4'd3:  r = 20'sd8150;
				4'd4:  r = 20'sd4091;
				4'd5:  r = 20'sd2047;
				4'd6:  r = 20'sd1024;
				4'd7:  r = 20'sd512;
				4'd8:  r = 20'sd256;
				4'd9:  r = 20'sd128;
				4'd10: r = 20'sd64;
				4'd11: r = 20'sd32;
				4'd12: r = 20'sd16;
				4'd13: r = 20'sd8;
				4'd14: r = 20'sd4;
				default: r = 20'sd2;
			endcase
			return r;
		end
	endfunction

	function automatic logic [30:0] sat31(input logic [63:0] v);
		logic [30:0] r;
		begin
			r = (v > {33'd0, SAT31}) ? SAT31 : v[30:0];
			return r;
		end
	endfunction

endpackage

// ===== rtl/core/wov_div.sv =====
module wov_div import wov_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic [63:0] quotient,
	output logic        done
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] dvd_q;
	logic [63:0] dsr_q;
	logic [63:0] quo_q;
	logic [63:0] rem_sh;
	logic        ge;

	// restoring division, one quotient bit a cycle
	assign rem_sh = {rem_q[62:0], dvd_q[63]};
	assign ge     = rem_sh >= dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - dsr_q) : rem_sh;
			dvd_q <= {dvd_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== rtl/core/wov_cordic.sv =====
module wov_cordic import wov_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] angle,
	output logic signed [18:0] sin_q16,
	output logic signed [18:0] cos_q16,
	output logic               busy
);

	logic               busy_q;
	logic [3:0]         cnt_q;
	logic               flip_q;
	logic signed [18:0] x_q;
	logic signed [18:0] y_q;
	logic signed [19:0] z_q;
	logic signed [19:0] z0;
	logic signed [19:0] z_init;
	logic               flip_init;
	logic signed [18:0] dx;
	logic signed [18:0] dy;
	logic signed [19:0] at;

	always_comb begin
		z0 = {angle[15], angle, 3'b000};
		z_init = z0;
		flip_init = 1'b0;
		// fold into the right half plane, negate the results later
		if (z0 > HALF_PI_Q16) begin
			z_init = z0 - PI_Q16;
			flip_init = 1'b1;
		end else if (z0 < -HALF_PI_Q16) begin
			z_init = z0 + PI_Q16;
			flip_init = 1'b1;
		end
	end

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign at = atan_q16(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN_Q16;
			y_q    <= '0;
			z_q    <= z_init;
			flip_q <= flip_init;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign sin_q16 = flip_q ? -y_q : y_q;
	assign cos_q16 = flip_q ? -x_q : x_q;
	assign busy    = busy_q;

endmodule

// ===== rtl/core/wov_dp.sv =====
module wov_dp import wov_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  in_t  in_data,
	input  cmd_t cmd,
	output sts_t sts,
	input  logic out_ready,
	output logic out_valid,
	output out_t out_data
);

	in_t                in_q;
	logic signed [15:0] angle_q;
	logic signed [31:0] lin_q;
	logic signed [31:0] yaw_q;
	logic [31:0]        rej_cnt_q;
	stat_e              code_q;
	logic [63:0]        prod_q;
	logic [30:0]        speed_mag_q;
	logic [30:0]        lin_mag_q;
	logic [30:0]        yaw_mag_q;
	logic               out_valid_q;
	out_t               out_q;

	logic [63:0]        period;
	logic               dneg;
	logic [31:0]        dmag;
	logic signed [18:0] sin_v;
	logic signed [18:0] cos_v;
	logic               cordic_busy;
	logic [18:0]        sin_mag;
	logic [18:0]        cos_mag;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic               div_start;
	logic [63:0]        div_dvd;
	logic [63:0]        div_dsr;
	logic [63:0]        div_quo;
	logic               div_done;
	logic [30:0]        wheel_dist;
	logic [30:0]        comp_mag;
	logic               reject;
	logic               lin_neg;
	logic               yaw_neg;

	assign period  = in_q.period_end_ns - in_q.period_start_ns;
	assign dneg    = in_q.displacement[31];
	assign dmag    = dneg ? (~in_q.displacement + 32'd1) : in_q.displacement;
	assign sin_mag = sin_v[18] ? -sin_v : sin_v;
	assign cos_mag = cos_v[18] ? -cos_v : cos_v;
	assign wheel_dist = (cfg.wheel_distance == '0) ? 31'd1 : cfg.wheel_distance;
	assign comp_mag = sat31({16'd0, prod_q[63:16]});
	assign lin_neg = dneg ^ cos_v[18];
	assign yaw_neg = dneg ^ sin_v[18];

	wov_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.spd_go),
		.angle   (angle_q),
		.sin_q16 (sin_v),
		.cos_q16 (cos_v),
		.busy    (cordic_busy)
	);

	always_comb begin
		div_start = cmd.spd_go | cmd.yaw_go;
		if (cmd.yaw_go) begin
			div_dvd = {17'd0, comp_mag, 16'd0};
			div_dsr = {33'd0, wheel_dist};
		end else begin
			div_dvd = prod_q;
			div_dsr = period;
		end
	end

	wov_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.quotient (div_quo),
		.done     (div_done)
	);

	// one shared multiplier
	always_comb begin
		if (cmd.spd_mul) begin
			mul_a = dmag;
			mul_b = NS_PER_S;
		end else if (cmd.lin_mul) begin
			mul_a = {1'b0, speed_mag_q};
			mul_b = {13'd0, cos_mag};
		end else begin
			mul_a = {1'b0, speed_mag_q};
			mul_b = {13'd0, sin_mag};
		end
	end

	assign reject = ({1'b0, lin_mag_q} >= {1'b0, cfg.max_linear_speed})
		|| (yaw_mag_q >= cfg.max_yaw_rate)
		|| (period >= {32'd0, cfg.max_period_ns});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
		if (cmd.spd_mul || cmd.lin_mul || cmd.cmp_mul) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.spd_take) begin
			speed_mag_q <= sat31(div_quo);
		end
		if (cmd.cmp_mul) begin
			lin_mag_q <= sat31({16'd0, prod_q[63:16]});
		end
		if (cmd.yaw_take) begin
			yaw_mag_q <= sat31(div_quo);
		end
		if (cmd.out_load) begin
			out_q.status          <= code_q;
			out_q.linear_velocity <= lin_q;
			out_q.yaw_rate        <= yaw_q;
			out_q.invalid_count   <= rej_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q     <= '0;
			lin_q       <= '0;
			yaw_q       <= '0;
			rej_cnt_q   <= '0;
			code_q      <= STAT_IGNORED;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.store_angle) begin
				angle_q <= in_q.steer_angle;
			end
			if (cmd.code_we) begin
				code_q <= cmd.code;
			end
			if (cmd.commit) begin
				if (reject) begin
					code_q <= STAT_REJECTED;
					if (rej_cnt_q != '1) begin
						rej_cnt_q <= rej_cnt_q + 32'd1;
					end
				end else begin
					code_q <= STAT_ACCEPTED;
					lin_q  <= lin_neg ? -{1'b0, lin_mag_q} : {1'b0, lin_mag_q};
					yaw_q  <= yaw_neg ? -{1'b0, yaw_mag_q} : {1'b0, yaw_mag_q};
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.is_enc      = in_q.action;
		sts.match       = in_q.action ? (in_q.unit_id == cfg.chosen_wheel)
			: (in_q.unit_id == cfg.chosen_servo);
		sts.bad_period  = (period == '0) || period[63];
		sts.div_done    = div_done;
		sts.cordic_busy = cordic_busy;
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/wov_ctrl.sv =====
module wov_ctrl import wov_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_e state_q;
	state_e state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (sts.match && sts.is_enc && !sts.bad_period) state_d = ST_SPD_MUL;
				else state_d = ST_DONE;
			end
			ST_SPD_MUL: state_d = ST_SPD_GO;
			ST_SPD_GO:  state_d = ST_SPD_DIV;
			ST_SPD_DIV: begin
				if (sts.div_done) state_d = ST_LIN_MUL;
			end
			ST_LIN_MUL: begin
				if (!sts.cordic_busy) state_d = ST_CMP_MUL;
			end
			ST_CMP_MUL: state_d = ST_YAW_GO;
			ST_YAW_GO:  state_d = ST_YAW_DIV;
			ST_YAW_DIV: begin
				if (sts.div_done) state_d = ST_CHECK;
			end
			ST_CHECK:   state_d = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.code = STAT_IGNORED;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DECODE: begin
				if (!sts.match) begin
					cmd.code_we = 1'b1;
					cmd.code    = STAT_IGNORED;
				end else if (!sts.is_enc) begin
					cmd.store_angle = 1'b1;
					cmd.code_we     = 1'b1;
					cmd.code        = STAT_ANGLE;
				end else if (sts.bad_period) begin
					cmd.code_we = 1'b1;
					cmd.code    = STAT_BAD_PERIOD;
				end
			end
			ST_SPD_MUL: cmd.spd_mul  = 1'b1;
			ST_SPD_GO:  cmd.spd_go   = 1'b1;
			ST_SPD_DIV: cmd.spd_take = sts.div_done;
			ST_LIN_MUL: cmd.lin_mul  = !sts.cordic_busy;
			ST_CMP_MUL: cmd.cmp_mul  = 1'b1;
			ST_YAW_GO:  cmd.yaw_go   = 1'b1;
			ST_YAW_DIV: cmd.yaw_take = sts.div_done;
			ST_CHECK:   cmd.commit   = 1'b1;
			ST_DONE:    cmd.out_load = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/core/wheel_odometry_velocity.sv =====
// Steered wheel odometry: servo requests from the chosen servo store the steer
// angle; encoder requests from the chosen wheel produce speed, linear velocity
// and yaw rate, which replace the stored velocities when inside the limits.
// Every request gives one result carrying a status and the stored values.
// One request is worked on at a time. A servo, foreign or bad-period request
// goes from the accept through the decode state to the done state; an
// encoder request that goes through the math runs two 64-step restoring
// divisions (speed, then yaw) in the one shared divider, and the 16-step
// CORDIC runs during the first division. The done state loads the result
// into an output register once that is free. A finished result waits in
// the output register while the next request is accepted.
module wheel_odometry_velocity import wov_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel_distance   <= 31'd32768;
			cfg_q.max_linear_speed <= 31'd327680;
			cfg_q.max_yaw_rate     <= 31'd327680;
			cfg_q.max_period_ns    <= 32'd200000000;
			cfg_q.chosen_wheel     <= '0;
			cfg_q.chosen_servo     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WHEEL_DIST: cfg_q.wheel_distance   <= cfg_data[30:0];
				CFG_MAX_LINEAR: cfg_q.max_linear_speed <= cfg_data[30:0];
				CFG_MAX_YAW:    cfg_q.max_yaw_rate     <= cfg_data[30:0];
				CFG_MAX_PERIOD: cfg_q.max_period_ns    <= cfg_data;
				CFG_WHEEL_ID:   cfg_q.chosen_wheel     <= cfg_data[3:0];
				CFG_SERVO_ID:   cfg_q.chosen_servo     <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	wov_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wov_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// one request in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	a_result_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a request in flight");

	a_reject_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STAT_REJECTED) |-> out_data.invalid_count != '0)
		else $error("rejected result with zero invalid count");

endmodule

// ===== tb/tb.sv =====
module tb;
	import wov_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	wheel_odometry_velocity dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of registers and state
	logic [30:0] m_dist, m_max_lin, m_max_yaw;
	logic [31:0] m_max_per;
	logic [3:0] m_wheel, m_servo;
	logic signed [15:0] m_angle;
	logic signed [31:0] m_lin, m_yaw;
	logic [31:0] m_rejects;

	in_t request_q[$];
	out_t odo_expected[$];
	int errors;
	int hold_off;
	bit cfg_busy;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	function automatic logic signed [31:0] asr(input logic signed [31:0] v, input int n);
		return v >>> n;
	endfunction

	function automatic logic signed [31:0] sat_signed(input bit neg, input logic [63:0] mag);
		logic [63:0] m;
		m = (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mag;
		return neg ? -$signed(m[31:0]) : $signed(m[31:0]);
	endfunction

	function automatic logic [63:0] abs32(input logic signed [31:0] v);
		logic signed [63:0] w;
		w = v;
		return (w < 0) ? -w : w;
	endfunction

	function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat_signed((a < 0) != (b < 0), (abs32(a) * abs32(b)) >> 16);
	endfunction

	task automatic rotate_angle(input logic signed [15:0] ang,
			output logic signed [31:0] s, output logic signed [31:0] c);
		logic signed [31:0] z, x, y, dx, dy;
		bit flip;
		int tbl[16];
		tbl = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		z = 32'(ang) * 8;
		x = 39797;
		y = 0;
		flip = 0;
		if (z > 102944) begin
			z -= 205887;
			flip = 1;
		end else if (z < -102944) begin
			z += 205887;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			dx = asr(y, i);
			dy = asr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= tbl[i];
			end else begin
				x += dx; y -= dy; z += tbl[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	task automatic predict_odometry(input in_t r);
		out_t o;
		logic [63:0] period, dmag, wheel_dist;
		logic signed [31:0] speed, s, c, lin, comp, yaw;
		bit dneg;
		o.status = STAT_IGNORED;
		if (!r.action) begin
			if (r.unit_id == m_servo) begin
				m_angle = r.steer_angle;
				o.status = STAT_ANGLE;
			end
		end else if (r.unit_id == m_wheel) begin
			period = r.period_end_ns - r.period_start_ns;
			if (period == 0 || period[63]) begin
				o.status = STAT_BAD_PERIOD;
			end else begin
				dneg = r.displacement < 0;
				dmag = abs32(r.displacement);
				speed = sat_signed(dneg, (dmag * 64'd1000000000) / period);
				wheel_dist = (m_dist == 0) ? 64'd1 : 64'(m_dist);
				rotate_angle(m_angle, s, c);
				lin = mulq(speed, c);
				comp = mulq(speed, s);
				yaw = sat_signed(comp < 0, (abs32(comp) << 16) / wheel_dist);
				if (abs32(lin) >= m_max_lin || abs32(yaw) >= m_max_yaw
						|| period >= 64'(m_max_per)) begin
					if (m_rejects != 32'hFFFF_FFFF) m_rejects++;
					o.status = STAT_REJECTED;
				end else begin
					m_lin = lin;
					m_yaw = yaw;
					o.status = STAT_ACCEPTED;
				end
			end
		end
		o.linear_velocity = m_lin;
		o.yaw_rate = m_yaw;
		o.invalid_count = m_rejects;
		odo_expected.push_back(o);
	endtask

	// driver
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_data <= '0;
			in_gap <= 0;
		end else if (in_valid && !in_ready) begin
		end else begin
			if (in_valid) predict_odometry(in_data);
			if (in_gap > 0) begin
				in_valid <= 0;
				in_gap <= in_gap - 1;
			end else if (request_q.size() > 0 && !cfg_busy) begin
				in_data <= request_q.pop_front();
				in_valid <= 1;
				in_gap <= $urandom_range(0, 3) * ($urandom_range(0, 3) == 0);
			end else begin
				in_valid <= 0;
			end
		end
	end

	// monitor
	int out_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			out_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (odo_expected.size() == 0) begin
					report("unexpected result", 64'(out_data.status), 64'd0);
				end else begin
					out_t e;
					e = odo_expected.pop_front();
					if (out_data.status !== e.status)
						report("status", 64'(out_data.status), 64'(e.status));
					if (out_data.linear_velocity !== e.linear_velocity)
						report("linear_velocity", 64'(out_data.linear_velocity),
							64'(e.linear_velocity));
					if (out_data.yaw_rate !== e.yaw_rate)
						report("yaw_rate", 64'(out_data.yaw_rate), 64'(e.yaw_rate));
					if (out_data.invalid_count !== e.invalid_count)
						report("invalid_count", 64'(out_data.invalid_count),
							64'(e.invalid_count));
				end
			end
			if (hold_off > 0) begin
				out_ready <= 0;
			end else if (out_gap > 0) begin
				out_ready <= 0;
				out_gap <= out_gap - 1;
			end else if (!out_ready || out_valid) begin
				out_ready <= 1;
				if (out_valid) out_gap <= $urandom_range(0, 3) * ($urandom_range(0, 2) == 0);
			end
		end
	end

	task automatic write_reg(input cfg_idx_e idx, input logic [31:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			CFG_WHEEL_DIST: m_dist = v[30:0];
			CFG_MAX_LINEAR: m_max_lin = v[30:0];
			CFG_MAX_YAW: m_max_yaw = v[30:0];
			CFG_MAX_PERIOD: m_max_per = v;
			CFG_WHEEL_ID: m_wheel = v[3:0];
			CFG_SERVO_ID: m_servo = v[3:0];
			default: ;
		endcase
	endtask

	task automatic drain_all();
		while (request_q.size() > 0 || in_valid || odo_expected.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic in_t make_request(input bit enc, input logic [3:0] id,
			input logic signed [15:0] ang, input logic signed [31:0] disp,
			input logic [63:0] start, input logic [63:0] per);
		in_t r;
		r.action = enc;
		r.unit_id = id;
		r.steer_angle = ang;
		r.displacement = disp;
		r.period_start_ns = start;
		r.period_end_ns = start + per;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic in_t random_request();
		in_t r;
		logic [63:0] per;
		logic signed [31:0] disp;
		int k;
		k = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0: per = 64'($urandom_range(1, 1000));
			1: per = 64'($urandom_range(1000000, 250000000));
			2: per = 64'($urandom_range(1, 4000000));
			default: per = rand64();
		endcase
		disp = ($urandom_range(0, 3) == 0) ? $signed($urandom())
			: $signed(32'($urandom_range(0, 65536))) - 32768;
		if (k < 10)
			r = make_request(1'($urandom_range(0, 1)), 4'($urandom()), 16'($urandom()),
				$urandom(), rand64(), rand64());
		else if (k < 40)
			r = make_request(0, (k < 36) ? m_servo : 4'($urandom()), 16'($urandom()),
				$urandom(), rand64(), rand64());
		else
			r = make_request(1, (k < 95) ? m_wheel : 4'($urandom()), 16'($urandom()), disp,
				rand64(), per);
		return r;
	endfunction

	task automatic run_random(input int n);
		repeat (n) request_q.push_back(random_request());
		drain_all();
	endtask

	initial begin
		errors = 0;
		hold_off = 0;
		cfg_busy = 0;
		cfg_valid = 0;
		cfg_index = CFG_WHEEL_DIST;
		cfg_data = 0;
		m_dist = 32768; m_max_lin = 327680; m_max_yaw = 327680;
		m_max_per = 200000000; m_wheel = 0; m_servo = 0;
		m_angle = 0; m_lin = 0; m_yaw = 0; m_rejects = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: angle extremes, bad periods, limits, foreign ids
		request_q.push_back(make_request(1, 0, 0, 32'sd65536, 5, 100000000));
		request_q.push_back(make_request(0, 0, 16'sh7FFF, 0, 0, 0));
		request_q.push_back(make_request(1, 0, 0, 32'sd6553, 0, 10000000));
		request_q.push_back(make_request(0, 0, -16'sh8000, 0, 0, 0));
		request_q.push_back(make_request(1, 0, 0, -32'sd6553, 0, 10000000));
		request_q.push_back(make_request(0, 0, 16'sd12868, 0, 0, 0));
		request_q.push_back(make_request(1, 0, 0, 32'sd3000, 0, 10000000));
		request_q.push_back(make_request(0, 0, -16'sd12868, 0, 0, 0));
		request_q.push_back(make_request(1, 0, 0, 32'sd3000, 0, 10000000));
		request_q.push_back(make_request(1, 0, 0, 32'sd100, 77, 0));
		request_q.push_back(make_request(1, 0, 0, 32'sd100, 500, 64'hFFFF_FFFF_FFFF_FF00));
		request_q.push_back(make_request(1, 0, 0, 32'sd100, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20));
		request_q.push_back(make_request(1, 0, 0, 32'h7FFF_FFFF, 0, 1));
		request_q.push_back(make_request(1, 0, 0, 32'h8000_0000, 0, 1));
		request_q.push_back(make_request(1, 0, 0, 32'sd10, 0, 200000000));
		request_q.push_back(make_request(1, 0, 0, 32'sd10, 0, 199999999));
		request_q.push_back(make_request(1, 4'hF, 0, 32'sd10, 0, 1000));
		request_q.push_back(make_request(0, 4'hF, 16'sh1234, 0, 0, 0));
		request_q.push_back(make_request(1, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF));
		drain_all();

		// back pressure: receiver stalls while requests keep coming
		for (int i = 0; i < 12; i++) request_q.push_back(random_request());
		hold_off = 1;
		repeat (600) @(posedge clk);
		hold_off = 0;
		drain_all();
		run_random(280);

		write_reg(CFG_WHEEL_DIST, 0);
		write_reg(CFG_MAX_LINEAR, 32'h7FFF_FFFF);
		write_reg(CFG_MAX_YAW, 32'h7FFF_FFFF);
		write_reg(CFG_MAX_PERIOD, 32'hFFFF_FFFF);
		write_reg(CFG_WHEEL_ID, 15);
		write_reg(CFG_SERVO_ID, 15);
		run_random(280);

		write_reg(CFG_WHEEL_DIST, 32'h7FFF_FFFF);
		write_reg(CFG_MAX_LINEAR, 0);
		write_reg(CFG_MAX_YAW, 0);
		write_reg(CFG_MAX_PERIOD, 1);
		write_reg(CFG_WHEEL_ID, 5);
		write_reg(CFG_SERVO_ID, 9);
		run_random(200);

		write_reg(CFG_WHEEL_DIST, 1);
		write_reg(CFG_MAX_LINEAR, 32'h0100_0000);
		write_reg(CFG_MAX_YAW, 32'h7FFF_FFFF);
		write_reg(CFG_MAX_PERIOD, 32'hFFFF_FFFF);
		write_reg(CFG_WHEEL_ID, 3);
		write_reg(CFG_SERVO_ID, 3);
		run_random(250);

		write_reg(CFG_WHEEL_DIST, $urandom_range(1000, 200000));
		write_reg(CFG_MAX_LINEAR, $urandom_range(10000, 2000000));
		write_reg(CFG_MAX_YAW, $urandom_range(10000, 2000000));
		write_reg(CFG_MAX_PERIOD, $urandom_range(100000, 300000000));
		write_reg(CFG_WHEEL_ID, $urandom());
		write_reg(CFG_SERVO_ID, $urandom());
		run_random(260);

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
